[sv/etm_pkg.sv]
// ----------------------------------------------------------------------------
// etm_pkg : shared constants and helpers for the Euler TRS matrix block
// Fixed-point widths, CORDIC constants, arctangent table, rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package etm_pkg;

	localparam int FRAC_BITS_DEF     = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// Q.30 working widths: angle path and CORDIC x/y path
	localparam int AW = 35;
	localparam int CW = 34;

	localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

	function automatic logic [31:0] etm_atan(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd843314857;
			1: r = 32'd497837829;
			2: r = 32'd263043837;
			3: r = 32'd133525159;
			4: r = 32'd67021687;
			5: r = 32'd33543516;
			6: r = 32'd16775851;
			7: r = 32'd8388437;
			8: r = 32'd4194283;
			9: r = 32'd2097149;
			10: r = 32'd1048576;
			11: r = 32'd524288;
			12: r = 32'd262144;
			13: r = 32'd131072;
			14: r = 32'd65536;
			15: r = 32'd32768;
			16: r = 32'd16384;
			17: r = 32'd8192;
			18: r = 32'd4096;
			19: r = 32'd2048;
			20: r = 32'd1024;
			21: r = 32'd512;
			22: r = 32'd256;
			23: r = 32'd128;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// Q.30 x Q.30 product, round half up, back to Q.30
	function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] pr;
		pr = (2*CW)'(a) * (2*CW)'(b);
		pr = pr + $signed({{(2*CW-30){1'b0}}, 1'b1, 29'b0});
		return CW'(pr >>> 30);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > $signed(36'h07FFFFFFF))
			r = 32'sh7FFFFFFF;
		else if (v < $signed(36'hF80000000))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/euler_trs_model_matrix.sv]
// ----------------------------------------------------------------------------
// euler_trs_model_matrix : Y-X-Z Euler scale-rotate-translate transform
//
//   channel | signals                        | direction | word
//   in      | in_valid/in_ready, 9 fields    | input     | angles, scales, shifts
//   out     | out_valid/out_ready, 12 fields | output    | 3 columns + translation
//   cfg     | cfg_valid/cfg_ready, cfg_data  | input     | normal_mode bit
//
// One word per cycle while the output is not stalled. The reciprocal divider
// resolves one quotient bit per stage over NW = max(2*FRAC_BITS,31)+2 bits.
// Reset clears valid bits and the mode register.
// A stalled output word freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_trs_model_matrix
	import etm_pkg::*;
#(
	parameter int FRAC_BITS     = FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] angle_x,
	input  wire logic signed [15:0] angle_y,
	input  wire logic signed [15:0] angle_z,
	input  wire logic signed [31:0] scale_x,
	input  wire logic signed [31:0] scale_y,
	input  wire logic signed [31:0] scale_z,
	input  wire logic signed [31:0] shift_x,
	input  wire logic signed [31:0] shift_y,
	input  wire logic signed [31:0] shift_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      col0_x,
	output logic signed [31:0]      col0_y,
	output logic signed [31:0]      col0_z,
	output logic signed [31:0]      col1_x,
	output logic signed [31:0]      col1_y,
	output logic signed [31:0]      col1_z,
	output logic signed [31:0]      col2_x,
	output logic signed [31:0]      col2_y,
	output logic signed [31:0]      col2_z,
	output logic signed [31:0]      move_x,
	output logic signed [31:0]      move_y,
	output logic signed [31:0]      move_z
);

	localparam int NW = ((2*FRAC_BITS > 31) ? 2*FRAC_BITS : 31) + 2;

	logic                 mode_q;
	logic                 en;
	logic                 f_vld;
	logic signed [15:0]   ang [3];
	logic signed [31:0]   scl [3], sft [3];
	logic signed [CW-1:0] fx [3], fy [3];
	logic                 fneg [3], fsgn [3], fzr [3];
	logic [NW-1:0]        fquo [3];
	logic signed [31:0]   fscl [3], fsft [3];
	logic signed [31:0]   ent [9], mov [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_valid)
			mode_q <= cfg_data;
	end

	// advance whenever the output word is empty or taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign ang = '{angle_x, angle_y, angle_z};
	assign scl = '{scale_x, scale_y, scale_z};
	assign sft = '{shift_x, shift_y, shift_z};

	etm_front #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.angle  (ang),
		.scale  (scl),
		.shift  (sft),
		.out_vld(f_vld),
		.x_o    (fx),
		.y_o    (fy),
		.neg_o  (fneg),
		.quo_o  (fquo),
		.sgn_o  (fsgn),
		.zr_o   (fzr),
		.scl_o  (fscl),
		.sft_o  (fsft)
	);

	etm_mat #(
		.FRAC_BITS(FRAC_BITS)
	) u_mat (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.mode   (mode_q),
		.in_vld (f_vld),
		.x_i    (fx),
		.y_i    (fy),
		.neg_i  (fneg),
		.quo_i  (fquo),
		.sgn_i  (fsgn),
		.zr_i   (fzr),
		.scl_i  (fscl),
		.sft_i  (fsft),
		.out_vld(out_valid),
		.ent_o  (ent),
		.mov_o  (mov)
	);

	assign col0_x = ent[0];
	assign col0_y = ent[1];
	assign col0_z = ent[2];
	assign col1_x = ent[3];
	assign col1_y = ent[4];
	assign col1_z = ent[5];
	assign col2_x = ent[6];
	assign col2_y = ent[7];
	assign col2_z = ent[8];
	assign move_x = mov[0];
	assign move_y = mov[1];
	assign move_z = mov[2];

endmodule
`default_nettype wire

[sv/etm_front.sv]
// ----------------------------------------------------------------------------
// etm_front : angle reduction, CORDIC chain and reciprocal divider chain
// One CORDIC iteration and one quotient bit per stage, all lanes in lockstep.
// ----------------------------------------------------------------------------
`default_nettype none
module etm_front
	import etm_pkg::*;
#(
	parameter int FRAC_BITS     = FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	localparam int NW = ((2*FRAC_BITS > 31) ? 2*FRAC_BITS : 31) + 2,
	localparam int L  = (CORDIC_STAGES > NW) ? CORDIC_STAGES : NW
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_vld,
	input  wire logic signed [15:0]   angle [3],
	input  wire logic signed [31:0]   scale [3],
	input  wire logic signed [31:0]   shift [3],
	output logic                      out_vld,
	output logic signed [CW-1:0]      x_o [3],
	output logic signed [CW-1:0]      y_o [3],
	output logic                      neg_o [3],
	output logic [NW-1:0]             quo_o [3],
	output logic                      sgn_o [3],
	output logic                      zr_o [3],
	output logic signed [31:0]        scl_o [3],
	output logic signed [31:0]        sft_o [3]
);

	localparam int RW = 34;

	logic                 v_s   [0:L];
	logic signed [AW-1:0] ang_s [0:L][3];
	logic signed [CW-1:0] x_s   [0:L][3];
	logic signed [CW-1:0] y_s   [0:L][3];
	logic                 neg_s [0:L][3];
	logic [RW-1:0]        rem_s [0:L][3];
	logic [NW-1:0]        quo_s [0:L][3];
	logic [NW-1:0]        num_s [0:L][3];
	logic [32:0]          mag_s [0:L][3];
	logic                 sgn_s [0:L][3];
	logic                 zr_s  [0:L][3];
	logic signed [31:0]   scl_s [0:L][3];
	logic signed [31:0]   sft_s [0:L][3];

	logic signed [AW-1:0] a_red [3];
	logic                 a_neg [3];
	logic [32:0]          s_mag [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			a_red[j] = $signed({{(AW-16){angle[j][15]}}, angle[j]}) <<< 17;
			a_neg[j] = 1'b0;
			if (a_red[j] > HALF_PI_Q30) begin
				a_red[j] = a_red[j] - PI_Q30;
				a_neg[j] = 1'b1;
			end else if (a_red[j] < -HALF_PI_Q30) begin
				a_red[j] = a_red[j] + PI_Q30;
				a_neg[j] = 1'b1;
			end
			s_mag[j] = scale[j][31] ? 33'(-{scale[j][31], scale[j]}) : {1'b0, scale[j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= L; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_vld;
			for (int k = 0; k < L; k++)
				v_s[k+1] <= v_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				ang_s[0][j] <= a_red[j];
				neg_s[0][j] <= a_neg[j];
				x_s[0][j]   <= GAIN_Q30;
				y_s[0][j]   <= '0;
				rem_s[0][j] <= '0;
				quo_s[0][j] <= '0;
				num_s[0][j] <= (NW'(1) << (2*FRAC_BITS)) + NW'(s_mag[j] >> 1);
				mag_s[0][j] <= s_mag[j];
				sgn_s[0][j] <= scale[j][31];
				zr_s[0][j]  <= (scale[j] == '0);
				scl_s[0][j] <= scale[j];
				sft_s[0][j] <= shift[j];
			end
		end
	end

	for (genvar k = 0; k < L; k++) begin : g_st
		// pass-through fields
		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					neg_s[k+1][j] <= neg_s[k][j];
					num_s[k+1][j] <= num_s[k][j];
					mag_s[k+1][j] <= mag_s[k][j];
					sgn_s[k+1][j] <= sgn_s[k][j];
					zr_s[k+1][j]  <= zr_s[k][j];
					scl_s[k+1][j] <= scl_s[k][j];
					sft_s[k+1][j] <= sft_s[k][j];
				end
			end
		end

		if (k < CORDIC_STAGES) begin : g_cor
			always_ff @(posedge clk) begin
				if (en) begin
					for (int j = 0; j < 3; j++) begin
						if (ang_s[k][j] >= 0) begin
							x_s[k+1][j]   <= x_s[k][j] - (y_s[k][j] >>> k);
							y_s[k+1][j]   <= y_s[k][j] + (x_s[k][j] >>> k);
							ang_s[k+1][j] <= ang_s[k][j] - $signed({{(AW-32){1'b0}}, etm_atan(k)});
						end else begin
							x_s[k+1][j]   <= x_s[k][j] + (y_s[k][j] >>> k);
							y_s[k+1][j]   <= y_s[k][j] - (x_s[k][j] >>> k);
							ang_s[k+1][j] <= ang_s[k][j] + $signed({{(AW-32){1'b0}}, etm_atan(k)});
						end
					end
				end
			end
		end else begin : g_cor_hold
			always_ff @(posedge clk) begin
				if (en) begin
					for (int j = 0; j < 3; j++) begin
						x_s[k+1][j]   <= x_s[k][j];
						y_s[k+1][j]   <= y_s[k][j];
						ang_s[k+1][j] <= ang_s[k][j];
					end
				end
			end
		end

		if (k < NW) begin : g_div
			logic [RW-1:0] shin [3];
			logic          ge   [3];
			always_comb begin
				for (int j = 0; j < 3; j++) begin
					shin[j] = {rem_s[k][j][RW-2:0], num_s[k][j][NW-1-k]};
					ge[j]   = (shin[j] >= {1'b0, mag_s[k][j]});
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					for (int j = 0; j < 3; j++) begin
						rem_s[k+1][j] <= ge[j] ? shin[j] - {1'b0, mag_s[k][j]} : shin[j];
						quo_s[k+1][j] <= {quo_s[k][j][NW-2:0], ge[j]};
					end
				end
			end
		end else begin : g_div_hold
			always_ff @(posedge clk) begin
				if (en) begin
					for (int j = 0; j < 3; j++) begin
						rem_s[k+1][j] <= rem_s[k][j];
						quo_s[k+1][j] <= quo_s[k][j];
					end
				end
			end
		end
	end

	assign out_vld = v_s[L];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			x_o[j]   = x_s[L][j];
			y_o[j]   = y_s[L][j];
			neg_o[j] = neg_s[L][j];
			quo_o[j] = quo_s[L][j];
			sgn_o[j] = sgn_s[L][j];
			zr_o[j]  = zr_s[L][j];
			scl_o[j] = scl_s[L][j];
			sft_o[j] = sft_s[L][j];
		end
	end

endmodule
`default_nettype wire

[sv/etm_mat.sv]
// ----------------------------------------------------------------------------
// etm_mat : rotation products, scale factors and saturated entries
// Stages: finish sin/cos and reciprocal, first products, sums, scale, round.
// ----------------------------------------------------------------------------
`default_nettype none
module etm_mat
	import etm_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int NW = ((2*FRAC_BITS > 31) ? 2*FRAC_BITS : 31) + 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 mode,
	input  wire logic                 in_vld,
	input  wire logic signed [CW-1:0] x_i [3],
	input  wire logic signed [CW-1:0] y_i [3],
	input  wire logic                 neg_i [3],
	input  wire logic [NW-1:0]        quo_i [3],
	input  wire logic                 sgn_i [3],
	input  wire logic                 zr_i [3],
	input  wire logic signed [31:0]   scl_i [3],
	input  wire logic signed [31:0]   sft_i [3],
	output logic                      out_vld,
	output logic signed [31:0]        ent_o [9],
	output logic signed [31:0]        mov_o [3]
);

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [CW-1:0] sn_s1 [3], cs_s1 [3];
	logic signed [31:0]   fac_s1 [3], fac_s2 [3], fac_s3 [3];
	logic signed [31:0]   mov_s1 [3], mov_s2 [3], mov_s3 [3], mov_s4 [3], mov_s5 [3];
	logic signed [CW-1:0] p_s2, q_s2, s2_s2, s3_s2, c3_s2;
	logic signed [CW-1:0] t_s2 [8];
	logic signed [CW-1:0] r_s3 [9];
	logic signed [65:0]   pr_s4 [9];
	logic signed [31:0]   ent_s5 [9];

	logic signed [31:0]   rcp [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (zr_i[j])
				rcp[j] = 32'sh7FFFFFFF;
			else if (!sgn_i[j])
				rcp[j] = (quo_i[j] > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : quo_i[j][31:0];
			else
				rcp[j] = (quo_i[j] >= NW'(33'h080000000)) ? 32'sh80000000
					: (~quo_i[j][31:0] + 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// lane order x=0, y=1, z=2; s1/c1 from y, s2/c2 from x, s3/c3 from z
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				sn_s1[j]  <= neg_i[j] ? -y_i[j] : y_i[j];
				cs_s1[j]  <= neg_i[j] ? -x_i[j] : x_i[j];
				fac_s1[j] <= mode ? rcp[j] : scl_i[j];
				mov_s1[j] <= mode ? '0 : sft_i[j];
			end

			p_s2    <= mul30(sn_s1[1], sn_s1[0]);
			q_s2    <= mul30(cs_s1[1], sn_s1[0]);
			t_s2[0] <= mul30(cs_s1[1], cs_s1[2]);
			t_s2[1] <= mul30(cs_s1[0], sn_s1[2]);
			t_s2[2] <= mul30(cs_s1[2], sn_s1[1]);
			t_s2[3] <= mul30(cs_s1[1], sn_s1[2]);
			t_s2[4] <= mul30(cs_s1[0], cs_s1[2]);
			t_s2[5] <= mul30(sn_s1[1], sn_s1[2]);
			t_s2[6] <= mul30(cs_s1[0], sn_s1[1]);
			t_s2[7] <= mul30(cs_s1[1], cs_s1[0]);
			s2_s2   <= sn_s1[0];
			s3_s2   <= sn_s1[2];
			c3_s2   <= cs_s1[2];
			fac_s2  <= fac_s1;
			mov_s2  <= mov_s1;

			r_s3[0] <= t_s2[0] + mul30(p_s2, s3_s2);
			r_s3[1] <= t_s2[1];
			r_s3[2] <= mul30(q_s2, s3_s2) - t_s2[2];
			r_s3[3] <= mul30(p_s2, c3_s2) - t_s2[3];
			r_s3[4] <= t_s2[4];
			r_s3[5] <= mul30(q_s2, c3_s2) + t_s2[5];
			r_s3[6] <= t_s2[6];
			r_s3[7] <= -s2_s2;
			r_s3[8] <= t_s2[7];
			fac_s3  <= fac_s2;
			mov_s3  <= mov_s2;

			for (int k = 0; k < 9; k++)
				pr_s4[k] <= 66'(r_s3[k]) * 66'(fac_s3[k/3]);
			mov_s4 <= mov_s3;

			for (int k = 0; k < 9; k++)
				ent_s5[k] <= sat32(36'((pr_s4[k] + $signed({36'b0, 1'b1, 29'b0})) >>> 30));
			mov_s5 <= mov_s4;
		end
	end

	assign out_vld = v_s5;
	assign ent_o   = ent_s5;
	assign mov_o   = mov_s5;

endmodule
`default_nettype wire

[sv/etm_chk.sv]
// ----------------------------------------------------------------------------
// etm_chk : port-level checks for the Euler TRS matrix block
// Watches handshakes, stall behavior and translation zeroing in normal mode.
// ----------------------------------------------------------------------------
`default_nettype none
module etm_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        cfg_data,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] col0_x,
	input wire logic [31:0] move_x,
	input wire logic [31:0] move_y,
	input wire logic [31:0] move_z
);

	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_valid && cfg_ready)
			mode_q <= cfg_data;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(col0_x))
		else $error("output word changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q |-> move_x == '0 && move_y == '0 && move_z == '0)
		else $error("translation not zero in normal mode");

endmodule

bind euler_trs_model_matrix etm_chk u_etm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_data (cfg_data),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.col0_x   (col0_x),
	.move_x   (move_x),
	.move_y   (move_y),
	.move_z   (move_z)
);
`default_nettype wire
